@@ design/ffha_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int MaxSegments = 256;
  localparam int HeapMax     = 65536;
  localparam int StartW      = 17;
  localparam int SizeW       = 16;
  localparam int OffW        = 16;
  localparam int HeapW       = 17;
  localparam int HdrW        = 6;
  localparam int CfgIdxW     = 2;
  localparam int StatusW     = 3;

  typedef enum logic [StatusW-1:0] {
    StOk     = 3'd0,
    StNoFit  = 3'd1,
    StFull   = 3'd2,
    StNull   = 3'd3,
    StNotBlk = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeap = 2'd0,
    CfgHdr  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic    init_wr;
    logic    accept;
    logic    eval;
    logic    step;
    logic    rd_next;
    logic    mark_used;
    logic    merge_prev;
    logic    merge_nxt;
    logic    final_wr;
    logic    scan_clr;
    logic    scan_inc;
    logic    split_new;
    logic    split_cur;
    logic    set_err;
    status_e err_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic is_free;
    logic off_zero;
    logic used;
    logic size_eq;
    logic size_gt;
    logic link_end;
    logic match;
    logic full;
    logic scan_live;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ design/ffha_if.sv @@
// Request and response channel interfaces.
`default_nettype none
interface ffha_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [ffha_pkg::SizeW-1:0]    req_size;
  logic [ffha_pkg::OffW-1:0]     free_offset;
  modport src (output valid, func, req_size, free_offset, input ready);
  modport snk (input valid, func, req_size, free_offset, output ready);
endinterface

interface ffha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffha_pkg::StatusW-1:0]  status;
  logic [ffha_pkg::OffW-1:0]     data_offset;
  logic [ffha_pkg::SizeW-1:0]    block_size;
  modport src (output valid, status, data_offset, block_size, input ready);
  modport snk (input valid, status, data_offset, block_size, output ready);
endinterface
`default_nettype wire

@@ design/first_fit_heap_allocator_top.sv @@
// Top level of the first-fit heap allocator with coalescing.
//
//   channel  dir  fields                                   beat
//   req_i    in   func, req_size, free_offset              valid & ready
//   rsp_o    out  status, data_offset, block_size          valid & ready
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i          cfg_we_i
//
// One request at a time. An allocate walks the segment list one entry per cycle
// through the table memory's registered read port, then a split scans the live
// bits one entry per cycle for a spare record; a free walks the same way, then
// merges with any free neighbour and writes the merged block back.
// After reset or a heap or header config write while idle, the init state re-forms the heap before the next request.
// A waiting response does not stall the following request until that one finishes.
`default_nettype none
module first_fit_heap_allocator_top #(
  parameter int MAX_SEGMENTS = ffha_pkg::MaxSegments
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ffha_req_if.snk                       req_i,
  ffha_rsp_if.src                       rsp_o,
  input  logic                          cfg_we_i,
  input  logic [ffha_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ffha_pkg::HeapW-1:0]    cfg_data_i
);

  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffha_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_func_i    (req_i.func),
    .in_size_i    (req_i.req_size),
    .in_off_i     (req_i.free_offset),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_status_o (rsp_o.status),
    .rsp_off_o    (rsp_o.data_offset),
    .rsp_size_o   (rsp_o.block_size),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.init_wr, cmd.mark_used, cmd.split_new, cmd.split_cur, cmd.final_wr}))
    else $error("more than one table write in a cycle");

  a_split_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.split_new |=> cmd.split_cur)
    else $error("split remainder not followed by block update");

  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.split_new |-> !sts.full)
    else $error("split with full segment table");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while another is in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.status <= ffha_pkg::StNotBlk))
    else $error("undefined status code");

endmodule
`default_nettype wire

@@ design/ffha_ctrl.sv @@
// Sequencer for list walk, split, merge and result hand-off.
`default_nettype none
module ffha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  ffha_pkg::sts_t sts_i,
  output ffha_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_NX   = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_SW2  = 3'd5;
  localparam logic [2:0] S_FW   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    req_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = !sts_i.cfg_hit;
        if (sts_i.cfg_hit) begin
          state_d = S_INIT;
        end else if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EV;
        end
      end
      S_EV: begin
        cmd_o.eval = 1'b1;
        if (sts_i.is_free && sts_i.off_zero) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = ffha_pkg::StNull;
          state_d        = S_DONE;
        end else if (!sts_i.is_free) begin
          if (!sts_i.used && sts_i.size_eq) begin
            cmd_o.mark_used = 1'b1;
            state_d         = S_DONE;
          end else if (!sts_i.used && sts_i.size_gt) begin
            if (sts_i.full) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = ffha_pkg::StFull;
              state_d        = S_DONE;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d        = S_SCAN;
            end
          end else if (sts_i.link_end) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ffha_pkg::StNoFit;
            state_d        = S_DONE;
          end else begin
            cmd_o.step    = 1'b1;
            cmd_o.rd_next = 1'b1;
          end
        end else begin
          if (sts_i.match) begin
            if (!sts_i.used) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = ffha_pkg::StNotBlk;
              state_d        = S_DONE;
            end else begin
              cmd_o.merge_prev = 1'b1;
              if (sts_i.link_end) begin
                state_d = S_FW;
              end else begin
                cmd_o.rd_next = 1'b1;
                state_d       = S_NX;
              end
            end
          end else if (sts_i.link_end) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ffha_pkg::StNotBlk;
            state_d        = S_DONE;
          end else begin
            cmd_o.step    = 1'b1;
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      S_NX: begin
        cmd_o.merge_nxt = 1'b1;
        state_d         = S_FW;
      end
      S_SCAN: begin
        if (!sts_i.scan_live) begin
          cmd_o.split_new = 1'b1;
          state_d         = S_SW2;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_SW2: begin
        cmd_o.split_cur = 1'b1;
        state_d         = S_DONE;
      end
      S_FW: begin
        cmd_o.final_wr = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/ffha_dp.sv @@
// Segment table memory, live bits, config registers and result registers.
`default_nettype none
module ffha_dp #(
  parameter int MAX_SEGMENTS = ffha_pkg::MaxSegments
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ffha_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ffha_pkg::HeapW-1:0]      cfg_data_i,
  input  logic                            in_func_i,
  input  logic [ffha_pkg::SizeW-1:0]      in_size_i,
  input  logic [ffha_pkg::OffW-1:0]       in_off_i,
  input  logic                            rsp_ready_i,
  output logic                            rsp_valid_o,
  output logic [ffha_pkg::StatusW-1:0]    rsp_status_o,
  output logic [ffha_pkg::OffW-1:0]       rsp_off_o,
  output logic [ffha_pkg::SizeW-1:0]      rsp_size_o,
  input  ffha_pkg::cmd_t                  cmd_i,
  output ffha_pkg::sts_t                  sts_o
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int LW = IW + 1;
  localparam int SW = ffha_pkg::StartW;
  localparam int ZW = ffha_pkg::SizeW;
  localparam logic [LW-1:0] EndMark = LW'(MAX_SEGMENTS);

  logic [SW-1:0] mem_start [MAX_SEGMENTS];
  logic [ZW-1:0] mem_size  [MAX_SEGMENTS];
  logic          mem_used  [MAX_SEGMENTS];
  logic [LW-1:0] mem_link  [MAX_SEGMENTS];

  logic [ffha_pkg::HeapW-1:0] heap_q;
  logic [ffha_pkg::HdrW-1:0]  hdr_q;
  logic [ffha_pkg::HdrW-1:0]  h;
  logic [ffha_pkg::HeapW-1:0] total;
  logic [ZW-1:0]              size0;

  logic                       func_q;
  logic [ZW-1:0]              req_q;
  logic [ffha_pkg::OffW-1:0]  off_q;

  logic [IW-1:0]  cur_q, scan_q, blk_q;
  logic [LW-1:0]  prev_q, blk_link_q, cur_link_q;
  logic           prev_used_q;
  logic [ZW-1:0]  prev_size_q, cur_size_q, blk_size_q, before_q;
  logic [SW-1:0]  cur_start_q;

  logic [SW-1:0]  rd_start_q;
  logic [ZW-1:0]  rd_size_q;
  logic           rd_used_q;
  logic [LW-1:0]  rd_link_q;

  logic [MAX_SEGMENTS-1:0] live_q;
  logic [LW-1:0]           count_q;

  logic                    rd_en;
  logic [IW-1:0]           rd_addr;
  logic [IW-1:0]           wr_addr;
  logic                    we_start, we_size, we_used, we_link;
  logic [SW-1:0]           wd_start;
  logic [ZW-1:0]           wd_size;
  logic                    wd_used;
  logic [LW-1:0]           wd_link;

  logic [SW:0]             rd_data_off;
  logic [SW:0]             cur_data_off;
  logic [ZW:0]             req_plus_h;
  logic [SW-1:0]           split_start;
  logic [ZW-1:0]           split_size;
  logic [ZW:0]             prev_merge;
  logic [ZW:0]             nxt_merge;
  logic                    prev_free;

  logic [ffha_pkg::StatusW-1:0] res_status_q;
  logic [ffha_pkg::OffW-1:0]    res_off_q;
  logic [ZW-1:0]                res_size_q;

  assign h     = (hdr_q == '0) ? ffha_pkg::HdrW'(1) : hdr_q;
  assign total = (heap_q > ffha_pkg::HeapW'(ffha_pkg::HeapMax)) ?
                 ffha_pkg::HeapW'(ffha_pkg::HeapMax) : heap_q;
  assign size0 = (total >= ffha_pkg::HeapW'(h)) ? ZW'(total - ffha_pkg::HeapW'(h)) : '0;

  assign rd_data_off  = {1'b0, rd_start_q} + (SW+1)'(h);
  assign cur_data_off = {1'b0, cur_start_q} + (SW+1)'(h);
  assign req_plus_h   = {1'b0, req_q} + (ZW+1)'(h);
  assign split_start  = SW'(cur_data_off + (SW+1)'(req_q));
  assign split_size   = ZW'({1'b0, cur_size_q} - req_plus_h);
  assign prev_merge   = {1'b0, prev_size_q} + {1'b0, rd_size_q} + (ZW+1)'(h);
  assign nxt_merge    = {1'b0, blk_size_q} + {1'b0, rd_size_q} + (ZW+1)'(h);
  assign prev_free    = (prev_q != EndMark) && !prev_used_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q <= ffha_pkg::HeapW'(65536);
      hdr_q  <= ffha_pkg::HdrW'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffha_pkg::CfgHeap: heap_q <= cfg_data_i;
        ffha_pkg::CfgHdr:  hdr_q  <= cfg_data_i[ffha_pkg::HdrW-1:0];
        default: ;
      endcase
    end
  end

  // memory read port
  assign rd_en   = cmd_i.accept | cmd_i.rd_next;
  assign rd_addr = cmd_i.accept ? '0 : (cmd_i.rd_next ? rd_link_q[IW-1:0] : cur_q);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_start_q <= mem_start[rd_addr];
      rd_size_q  <= mem_size[rd_addr];
      rd_used_q  <= mem_used[rd_addr];
      rd_link_q  <= mem_link[rd_addr];
    end
  end

  // memory write port
  always_comb begin
    wr_addr  = cur_q;
    we_start = 1'b0;
    we_size  = 1'b0;
    we_used  = 1'b0;
    we_link  = 1'b0;
    wd_start = '0;
    wd_size  = '0;
    wd_used  = 1'b0;
    wd_link  = EndMark;
    if (cmd_i.init_wr) begin
      wr_addr  = '0;
      we_start = 1'b1;
      we_size  = 1'b1;
      we_used  = 1'b1;
      we_link  = 1'b1;
      wd_size  = size0;
    end else if (cmd_i.mark_used) begin
      we_used = 1'b1;
      wd_used = 1'b1;
    end else if (cmd_i.split_new) begin
      wr_addr  = scan_q;
      we_start = 1'b1;
      we_size  = 1'b1;
      we_used  = 1'b1;
      we_link  = 1'b1;
      wd_start = split_start;
      wd_size  = split_size;
      wd_link  = cur_link_q;
    end else if (cmd_i.split_cur) begin
      we_size = 1'b1;
      we_used = 1'b1;
      we_link = 1'b1;
      wd_size = req_q;
      wd_used = 1'b1;
      wd_link = {1'b0, scan_q};
    end else if (cmd_i.final_wr) begin
      wr_addr = blk_q;
      we_size = 1'b1;
      we_used = 1'b1;
      we_link = 1'b1;
      wd_size = blk_size_q;
      wd_link = blk_link_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_start) mem_start[wr_addr] <= wd_start;
    if (we_size)  mem_size[wr_addr]  <= wd_size;
    if (we_used)  mem_used[wr_addr]  <= wd_used;
    if (we_link)  mem_link[wr_addr]  <= wd_link;
  end

  // request and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= in_func_i;
      req_q  <= in_size_i;
      off_q  <= in_off_i;
    end
    if (cmd_i.eval) begin
      cur_start_q <= rd_start_q;
      cur_size_q  <= rd_size_q;
      cur_link_q  <= rd_link_q;
    end
    if (cmd_i.step) begin
      prev_used_q <= rd_used_q;
      prev_size_q <= rd_size_q;
    end
    if (cmd_i.merge_prev) begin
      before_q   <= rd_size_q;
      blk_link_q <= rd_link_q;
      if (prev_free) begin
        blk_q      <= prev_q[IW-1:0];
        blk_size_q <= ZW'(prev_merge);
      end else begin
        blk_q      <= cur_q;
        blk_size_q <= rd_size_q;
      end
    end else if (cmd_i.merge_nxt && !rd_used_q) begin
      blk_size_q <= ZW'(nxt_merge);
      blk_link_q <= rd_link_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      prev_q <= EndMark;
      scan_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        cur_q  <= '0;
        prev_q <= EndMark;
      end else if (cmd_i.step) begin
        cur_q  <= rd_link_q[IW-1:0];
        prev_q <= {1'b0, cur_q};
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + IW'(1);
      end
    end
  end

  // live bits and live count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= MAX_SEGMENTS'(1);
      count_q <= LW'(1);
    end else if (cmd_i.init_wr) begin
      live_q  <= MAX_SEGMENTS'(1);
      count_q <= LW'(1);
    end else if (cmd_i.split_new) begin
      live_q[scan_q] <= 1'b1;
      count_q        <= count_q + LW'(1);
    end else if (cmd_i.merge_prev && prev_free) begin
      live_q[cur_q] <= 1'b0;
      count_q       <= count_q - LW'(1);
    end else if (cmd_i.merge_nxt && !rd_used_q) begin
      live_q[blk_link_q[IW-1:0]] <= 1'b0;
      count_q                    <= count_q - LW'(1);
    end
  end

  // result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_used) begin
      res_status_q <= ffha_pkg::StOk;
      res_off_q    <= ffha_pkg::OffW'(rd_data_off);
      res_size_q   <= req_q;
    end else if (cmd_i.split_cur) begin
      res_status_q <= ffha_pkg::StOk;
      res_off_q    <= ffha_pkg::OffW'(cur_data_off);
      res_size_q   <= req_q;
    end else if (cmd_i.final_wr) begin
      res_status_q <= ffha_pkg::StOk;
      res_off_q    <= off_q;
      res_size_q   <= before_q;
    end else if (cmd_i.set_err) begin
      res_status_q <= cmd_i.err_code;
      res_off_q    <= (cmd_i.err_code == ffha_pkg::StNotBlk) ? off_q : '0;
      res_size_q   <= '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      rsp_valid_o <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_status_o <= res_status_q;
      rsp_off_o    <= res_off_q;
      rsp_size_o   <= res_size_q;
    end
  end

  always_comb begin
    sts_o.cfg_hit   = cfg_we_i &&
                      (cfg_idx_i == ffha_pkg::CfgHeap || cfg_idx_i == ffha_pkg::CfgHdr);
    sts_o.is_free   = func_q;
    sts_o.off_zero  = (off_q == '0);
    sts_o.used      = rd_used_q;
    sts_o.size_eq   = (rd_size_q == req_q);
    sts_o.size_gt   = ({1'b0, rd_size_q} > req_plus_h);
    sts_o.link_end  = (rd_link_q == EndMark);
    sts_o.match     = (rd_data_off == (SW+1)'(off_q));
    sts_o.full      = (count_q == LW'(MAX_SEGMENTS));
    sts_o.scan_live = live_q[scan_q];
    sts_o.out_free  = !rsp_valid_o || rsp_ready_i;
  end

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the first-fit heap allocator: directed table, then random phases.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSeg = ffha_pkg::MaxSegments;
  localparam int WatchLimit = 20000;
  localparam logic [ffha_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct {
    ffha_pkg::status_e st;
    logic [15:0]       off;
    logic [15:0]       sz;
  } grant_t;

  typedef struct {
    logic        func;
    logic [15:0] size;
    logic [15:0] off;
    bit          typed;
    grant_t      res;
  } row_t;

  typedef struct {
    int heap;
    int hdr;
    int smax;
    int palloc;
    int items;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ffha_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ffha_pkg::HeapW-1:0] cfg_data_i = '0;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator_top dut (
    .clk_i, .rst_ni, .req_i(req), .rsp_o(rsp),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // allocator mirror
  int heap_cfg, hdr_cfg;
  int s_start[NSeg], s_size[NSeg], s_link[NSeg];
  bit s_used[NSeg], s_live[NSeg];

  function automatic int hdr_now();
    return (hdr_cfg == 0) ? 1 : hdr_cfg;
  endfunction

  function automatic void heap_reform();
    int total;
    total = (heap_cfg > ffha_pkg::HeapMax) ? ffha_pkg::HeapMax : heap_cfg;
    for (int i = 0; i < NSeg; i++) begin
      s_start[i] = 0; s_size[i] = 0; s_link[i] = 0; s_used[i] = 1'b0; s_live[i] = 1'b0;
    end
    s_size[0] = (total >= hdr_now()) ? total - hdr_now() : 0;
    s_link[0] = NSeg;
    s_live[0] = 1'b1;
  endfunction

  function automatic grant_t mk(ffha_pkg::status_e st, int off, int sz);
    grant_t g;
    g.st = st; g.off = off[15:0]; g.sz = sz[15:0];
    return g;
  endfunction

  function automatic grant_t heap_alloc(int want);
    int h, cur, n;
    h = hdr_now();
    cur = 0;
    for (int steps = 0; steps < NSeg && cur < NSeg; steps++) begin
      if (!s_used[cur]) begin
        if (s_size[cur] == want) begin
          s_used[cur] = 1'b1;
          return mk(ffha_pkg::StOk, s_start[cur] + h, want);
        end
        if (s_size[cur] > want + h) begin
          n = NSeg;
          for (int i = 0; i < NSeg; i++)
            if (!s_live[i]) begin n = i; break; end
          if (n >= NSeg) return mk(ffha_pkg::StFull, 0, 0);
          s_live[n] = 1'b1; s_used[n] = 1'b0;
          s_start[n] = s_start[cur] + h + want;
          s_size[n] = s_size[cur] - want - h;
          s_link[n] = s_link[cur];
          s_link[cur] = n;
          s_size[cur] = want;
          s_used[cur] = 1'b1;
          return mk(ffha_pkg::StOk, s_start[cur] + h, want);
        end
      end
      cur = s_link[cur];
    end
    return mk(ffha_pkg::StNoFit, 0, 0);
  endfunction

  function automatic grant_t heap_release(int off);
    int h, cur, prev, steps, blk, nxt, was;
    h = hdr_now();
    cur = 0; prev = NSeg;
    if (off == 0) return mk(ffha_pkg::StNull, 0, 0);
    for (steps = 0; steps < NSeg && cur < NSeg; steps++) begin
      if (s_start[cur] + h == off) break;
      prev = cur;
      cur = s_link[cur];
    end
    if (steps >= NSeg || cur >= NSeg || !s_used[cur]) return mk(ffha_pkg::StNotBlk, off, 0);
    was = s_size[cur];
    blk = cur;
    nxt = s_link[cur];
    if (prev < NSeg && !s_used[prev]) begin
      s_size[prev] += s_size[cur] + h;
      s_link[prev] = nxt;
      s_live[cur] = 1'b0; s_used[cur] = 1'b0;
      blk = prev;
    end
    if (nxt < NSeg && !s_used[nxt]) begin
      s_size[blk] += s_size[nxt] + h;
      s_link[blk] = s_link[nxt];
      s_live[nxt] = 1'b0;
    end
    s_used[blk] = 1'b0;
    return mk(ffha_pkg::StOk, off, was);
  endfunction

  grant_t pending_q[$];
  int granted_q[$];
  int errors = 0;
  bit req_beat = 1'b0;
  row_t cur_row;
  int idle_mode = 0;
  int quiet = 0;

  // beat monitor
  always @(posedge clk_i) begin
    grant_t g, e;
    req_beat = req.valid && req.ready;
    if (req_beat) begin
      g = cur_row.func ? heap_release(int'(cur_row.off)) : heap_alloc(int'(cur_row.size));
      if (g.st == ffha_pkg::StOk && !cur_row.func) granted_q.push_back(int'(g.off));
      pending_q.push_back(cur_row.typed ? cur_row.res : g);
    end
    if (rsp.valid && rsp.ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response st=%0d", rsp.status);
      end else begin
        e = pending_q.pop_front();
        if (rsp.status !== e.st || rsp.data_offset !== e.off || rsp.block_size !== e.sz) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d off=%0d sz=%0d got st=%0d off=%0d sz=%0d",
                     e.st, e.off, e.sz, rsp.status, rsp.data_offset, rsp.block_size);
        end
      end
    end
    if (req_beat || (rsp.valid && rsp.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic bit stall_now(bit sender);
    int pct;
    case (idle_mode)
      1: pct = sender ? 83 : 0;
      2: pct = sender ? 0 : 83;
      3: pct = 26;
      default: pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  always @(negedge clk_i) rsp.ready = rst_ni && !stall_now(1'b0);

  task automatic send(row_t r);
    while (stall_now(1'b1)) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    cur_row = r;
    req.valid = 1'b1;
    req.func = r.func;
    req.req_size = r.size;
    req.free_offset = r.off;
    do @(negedge clk_i); while (!req_beat);
  endtask

  task automatic cfg_write(logic [ffha_pkg::CfgIdxW-1:0] idx, int val);
    req.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val[ffha_pkg::HeapW-1:0];
    if (idx == ffha_pkg::CfgHeap) begin heap_cfg = val & 32'h1FFFF; heap_reform(); end
    else if (idx == ffha_pkg::CfgHdr) begin hdr_cfg = val & 32'h3F; heap_reform(); end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    granted_q.delete();
  endtask

  function automatic row_t rnd_row(phase_t p);
    row_t r;
    int k, pick, i;
    r.typed = 1'b0; r.res = mk(ffha_pkg::StOk, 0, 0);
    r.func = 1'b0; r.size = '0; r.off = '0;
    k = $urandom_range(99);
    if (k < 6) begin
      r.func = 1'($urandom_range(1)); r.size = 16'($urandom); r.off = 16'($urandom);
    end else if (k < 8) begin
      r.func = 1'b1; r.off = '0; r.size = 16'($urandom);
    end else if (k < p.palloc || granted_q.size() == 0) begin
      r.size = 16'($urandom_range(p.smax));
      if ($urandom_range(4) == 0) begin
        pick = $urandom_range(NSeg - 1);
        for (i = 0; i < NSeg; i++)
          if (s_live[(pick + i) % NSeg] && !s_used[(pick + i) % NSeg]) begin
            r.size = 16'(s_size[(pick + i) % NSeg]); break;
          end
      end
      r.off = 16'($urandom);
    end else begin
      pick = $urandom_range(granted_q.size() - 1);
      r.func = 1'b1; r.off = 16'(granted_q[pick]); r.size = 16'($urandom);
      granted_q.delete(pick);
    end
    return r;
  endfunction

  row_t dir_rows[$] = '{
    '{1'b0, 16'd65520, 16'd0, 1'b1, '{ffha_pkg::StOk, 16'd16, 16'd65520}},
    '{1'b1, 16'd0, 16'd16, 1'b1, '{ffha_pkg::StOk, 16'd16, 16'd65520}},
    '{1'b1, 16'd0, 16'd16, 1'b1, '{ffha_pkg::StNotBlk, 16'd16, 16'd0}},
    '{1'b1, 16'hFFFF, 16'd0, 1'b1, '{ffha_pkg::StNull, 16'd0, 16'd0}},
    '{1'b1, 16'd0, 16'd5, 1'b1, '{ffha_pkg::StNotBlk, 16'd5, 16'd0}},
    '{1'b0, 16'hFFFF, 16'hFFFF, 1'b1, '{ffha_pkg::StNoFit, 16'd0, 16'd0}},
    '{1'b0, 16'd0, 16'd0, 1'b1, '{ffha_pkg::StOk, 16'd16, 16'd0}},
    '{1'b0, 16'd100, 16'd0, 1'b0, '{ffha_pkg::StOk, 16'd0, 16'd0}},
    '{1'b0, 16'd200, 16'd0, 1'b0, '{ffha_pkg::StOk, 16'd0, 16'd0}},
    '{1'b0, 16'd300, 16'd0, 1'b0, '{ffha_pkg::StOk, 16'd0, 16'd0}},
    '{1'b1, 16'd0, 16'd148, 1'b0, '{ffha_pkg::StOk, 16'd0, 16'd0}},
    '{1'b1, 16'd0, 16'd32, 1'b0, '{ffha_pkg::StOk, 16'd0, 16'd0}},
    '{1'b1, 16'd0, 16'd364, 1'b0, '{ffha_pkg::StOk, 16'd0, 16'd0}},
    '{1'b1, 16'd0, 16'd16, 1'b0, '{ffha_pkg::StOk, 16'd0, 16'd0}},
    '{1'b1, 16'd0, 16'hFFFF, 1'b1, '{ffha_pkg::StNotBlk, 16'hFFFF, 16'd0}},
    '{1'b0, 16'd65519, 16'd0, 1'b0, '{ffha_pkg::StOk, 16'd0, 16'd0}}
  };

  phase_t phases[$] = '{
    '{65536, 16, 2000, 60, 80},
    '{64, 1, 20, 55, 60},
    '{131071, 0, 4, 65, 60},
    '{65536, 1, 1, 95, 330},
    '{10, 32, 3, 60, 30},
    '{1000, 32, 100, 60, 100},
    '{4096, 8, 300, 60, 120},
    '{65536, 32, 65535, 60, 120}
  };

  initial begin
    heap_cfg = 65536; hdr_cfg = 16;
    heap_reform();
    req.valid = 1'b0; req.func = 1'b0; req.req_size = '0; req.free_offset = '0;
    rsp.ready = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (dir_rows[i]) send(dir_rows[i]);
    cfg_write(CfgSpare, 123);
    foreach (phases[p]) begin
      idle_mode = p % 4;
      cfg_write(ffha_pkg::CfgHeap, phases[p].heap);
      cfg_write(ffha_pkg::CfgHdr, phases[p].hdr);
      for (int n = 0; n < phases[p].items; n++) send(rnd_row(phases[p]));
    end
    req.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
